[rtl/core/tcc_pkg.sv]
package tcc_pkg;

	localparam int CHAR_W  = 8;
	localparam int GLYPH_W = 7;
	localparam int COL_W   = 8;
	localparam int ROW_W   = 6;
	localparam int CMD_W   = 2;

	localparam int TEXT_COLUMNS_DEF = 160;
	localparam int TEXT_ROWS_DEF    = 50;

	localparam logic [CHAR_W-1:0] CH_CTRL_LAST = 8'd31;
	localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
	localparam logic [CHAR_W-1:0] CH_DEL       = 8'd127;
	localparam logic [GLYPH_W-1:0] GLYPH_UNDERSCORE = 7'd95;

	typedef enum logic [CMD_W-1:0] {
		CMD_DRAW   = 2'd0,
		CMD_ERASE  = 2'd1,
		CMD_SCROLL = 2'd2,
		CMD_ERROR  = 2'd3
	} cmd_t;

	// request from the sequencer to the row record store
	typedef struct packed {
		logic             wr_en;
		logic [ROW_W-1:0] wr_row;
		logic [COL_W-1:0] wr_col;
		logic [ROW_W-1:0] rd_row;
		logic             scroll;
	} rec_req_t;

endpackage

[rtl/core/text_console_cursor_engine_top.sv]
// Requests are taken only in the idle state: a new one is accepted only after the
// commands of the last have been loaded. A delete that moves up a row first reads
// the record of the row above. Output back-pressure stalls the sequence.
// The row record lives in a RAM with registered read; scroll rotates its base.
// Reset clears cursor, halted flag, scroll offset and per-row valid bits.
module text_console_cursor_engine_top
	import tcc_pkg::*;
#(
	parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
	parameter int TEXT_ROWS    = TEXT_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic        s_axis_tuser,  // [0] first_of_string
	input  logic        s_axis_tlast,  // last_of_string
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [6:0] glyph, [14:7] column, [20:15] row
	output logic [1:0]  m_axis_tuser,  // [1:0] command
	output logic        m_axis_tlast   // final_command
);

	localparam logic [COL_W-1:0] ColLast = COL_W'(TEXT_COLUMNS - 1);
	localparam logic [ROW_W-1:0] RowLast = ROW_W'(TEXT_ROWS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_CHAR,
		ST_DLOAD,
		ST_DERASE,
		ST_SCROLL,
		ST_LAST
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [GLYPH_W-1:0] glyph;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic               fin;
	} ocmd_t;

	function automatic ocmd_t mk(input cmd_t c, input logic [GLYPH_W-1:0] g,
		input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y, input logic f);
		ocmd_t o;
		o.cmd   = c;
		o.glyph = g;
		o.col   = x;
		o.row   = y;
		o.fin   = f;
		return o;
	endfunction

	state_t            state_q;
	logic              halted_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CHAR_W-1:0] char_q;
	logic              first_q;
	logic              last_q;
	ocmd_t             out_q;
	logic              m_valid_q;

	logic              out_free;
	logic              out_load;
	logic              is_print, is_nl, is_del;
	logic              wrap, wrap_scroll;
	rec_req_t          rec_req;
	logic [COL_W-1:0]  rd_col;

	assign out_free    = !m_valid_q || m_axis_tready;
	assign is_print    = (char_q > CH_CTRL_LAST) && (char_q < CH_DEL);
	assign is_nl       = (char_q == CH_LF) || (char_q == CH_CR);
	assign is_del      = (char_q == CH_DEL);
	assign wrap        = (col_q == ColLast);
	assign wrap_scroll = wrap && (row_q == RowLast);

	// a command is loaded into the output register this cycle
	assign out_load = out_free && (
		(state_q == ST_FIRST && first_q) ||
		(state_q == ST_CHAR && !is_nl && !is_del) ||
		(state_q inside {ST_DERASE, ST_SCROLL}) ||
		(state_q == ST_LAST && last_q));

	always_comb begin
		rec_req        = '0;
		rec_req.wr_row = row_q;
		rec_req.rd_row = (row_q == '0) ? '0 : row_q - 1'b1;
		case (state_q)
			ST_CHAR: begin
				if (is_print && out_free) begin
					rec_req.wr_en  = 1'b1;
					rec_req.wr_col = col_q;
				end else if (is_del && (col_q != '0 || row_q != '0)) begin
					rec_req.wr_en  = 1'b1;
					rec_req.wr_col = (col_q != '0) ? col_q - 1'b1 : '0;
				end
			end
			ST_SCROLL: begin
				rec_req.scroll = out_free;
			end
			default: ;
		endcase
	end

	tcc_row_rec #(
		.TEXT_ROWS(TEXT_ROWS)
	) u_row_rec (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (rec_req),
		.rd_col(rd_col)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			halted_q  <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
			char_q    <= '0;
			first_q   <= 1'b0;
			last_q    <= 1'b0;
			out_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= out_load || (m_valid_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					// requests arriving while halted are dropped
					if (s_axis_tvalid && !halted_q) begin
						char_q  <= s_axis_tdata;
						first_q <= s_axis_tuser;
						last_q  <= s_axis_tlast;
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					if (!first_q) begin
						state_q <= ST_CHAR;
					end else if (out_free) begin
						out_q <= mk(CMD_ERASE, '0, col_q, row_q,
							is_nl && (row_q != RowLast) && !last_q);
						state_q   <= ST_CHAR;
					end
				end
				ST_CHAR: begin
					if (is_print) begin
						if (out_free) begin
							out_q <= mk(CMD_DRAW, char_q[GLYPH_W-1:0], col_q, row_q,
								!wrap_scroll && !last_q);
							col_q <= wrap ? '0 : col_q + 1'b1;
							if (wrap && !wrap_scroll) begin
								row_q <= row_q + 1'b1;
							end
							state_q <= wrap_scroll ? ST_SCROLL : ST_LAST;
						end
					end else if (is_nl) begin
						col_q <= '0;
						if (row_q == RowLast) begin
							state_q <= ST_SCROLL;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_LAST;
						end
					end else if (is_del) begin
						if (col_q != '0) begin
							col_q   <= col_q - 1'b1;
							state_q <= ST_DERASE;
						end else if (row_q != '0) begin
							// record of the row above is read this cycle
							row_q   <= row_q - 1'b1;
							state_q <= ST_DLOAD;
						end else begin
							state_q <= ST_DERASE;
						end
					end else if (out_free) begin
						out_q     <= mk(CMD_ERROR, '0, '0, '0, 1'b1);
						halted_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_DLOAD: begin
					col_q   <= rd_col;
					state_q <= ST_DERASE;
				end
				ST_DERASE: begin
					if (out_free) begin
						out_q     <= mk(CMD_ERASE, '0, col_q, row_q, !last_q);
						state_q   <= ST_LAST;
					end
				end
				ST_SCROLL: begin
					if (out_free) begin
						out_q     <= mk(CMD_SCROLL, '0, '0, '0, !last_q);
						state_q   <= ST_LAST;
					end
				end
				ST_LAST: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_q     <= mk(CMD_DRAW, GLYPH_UNDERSCORE, col_q, row_q, 1'b1);
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.row, out_q.col, out_q.glyph};
	assign m_axis_tuser  = out_q.cmd;
	assign m_axis_tlast  = out_q.fin;

	a_halt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> state_q == ST_IDLE)
		else $error("sequencer busy while halted");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= ColLast && row_q <= RowLast)
		else $error("cursor out of range");
	a_error_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == CMD_ERROR) |-> m_axis_tlast)
		else $error("error command not final");
	a_scroll_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == CMD_SCROLL) |-> m_axis_tdata == '0)
		else $error("scroll command carries a cell");
	a_dload_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DLOAD |=> state_q == ST_DERASE)
		else $error("record load not followed by erase");

endmodule

[rtl/core/tcc_ram.sv]
module tcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/core/tcc_row_rec.sv]
module tcc_row_rec
	import tcc_pkg::*;
#(
	parameter int TEXT_ROWS = TEXT_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rec_req_t         req,
	output logic [COL_W-1:0] rd_col
);

	localparam int AW = $clog2(TEXT_ROWS);
	localparam logic [AW:0] RowsW = (AW + 1)'(TEXT_ROWS);
	localparam logic [AW-1:0] BaseLast = AW'(TEXT_ROWS - 1);

	// screen row -> physical entry, rotated by the scroll offset
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] r, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, r} + {1'b0, b};
		if (s >= RowsW) begin
			s = s - RowsW;
		end
		return s[AW-1:0];
	endfunction

	logic [AW-1:0]        base_q;
	logic [TEXT_ROWS-1:0] valid_q;
	logic                 rd_vld_q;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;
	logic [COL_W-1:0]     ram_q;

	assign wr_addr = phys(req.wr_row[AW-1:0], base_q);
	assign rd_addr = phys(req.rd_row[AW-1:0], base_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			if (req.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (req.scroll) begin
				// old top row becomes the new, empty bottom row
				valid_q[base_q] <= 1'b0;
				base_q <= (base_q == BaseLast) ? '0 : base_q + 1'b1;
			end
		end
	end

	tcc_ram #(
		.WIDTH(COL_W),
		.DEPTH(TEXT_ROWS)
	) u_ram (
		.clk    (clk),
		.wr_en  (req.wr_en),
		.wr_addr(wr_addr),
		.wr_data(req.wr_col),
		.rd_addr(rd_addr),
		.rd_data(ram_q)
	);

	assign rd_col = rd_vld_q ? ram_q : '0;

	a_no_wr_on_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr_en && req.scroll))
		else $error("record write and scroll in the same cycle");
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		base_q <= BaseLast)
		else $error("scroll offset out of range");
	a_scroll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		req.scroll |=> !valid_q[$past(base_q)])
		else $error("scrolled-in row not cleared");

endmodule

[sim/tb_text_console_cursor_engine_top.sv]
module tb_text_console_cursor_engine_top;
	import tcc_pkg::*;

	localparam int COLS = TEXT_COLUMNS_DEF;
	localparam int ROWS = TEXT_ROWS_DEF;
	localparam int CHAR_TARGET = 420;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER = 120;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              first;
		logic              last;
	} char_req_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [GLYPH_W-1:0] glyph;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic               fin;
	} disp_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	text_console_cursor_engine_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	char_req_t char_feed[$];
	disp_cmd_t due_cmds[$];
	disp_cmd_t char_cmds[$];
	disp_cmd_t want;
	disp_cmd_t got;
	char_req_t next_req;

	// console state as predicted
	int               cur_col;
	int               cur_row;
	logic [COL_W-1:0] row_rec [ROWS];
	bit               halted_q;

	int errors = 0;
	int total_chars;
	int sent_cnt;
	int load_phase;
	int results_seen;
	int hold_left;
	bit hold_done;

	function automatic int idle_pct(input int ph, input bit rx);
		case (ph)
			0: return rx ? 56 : 7;
			1: return rx ? 7 : 56;
			default: return 0;
		endcase
	endfunction

	task automatic emit_cmd(input cmd_t c, input logic [GLYPH_W-1:0] g, input int col,
			input int row);
		disp_cmd_t d;
		d.cmd = c;
		d.glyph = g;
		d.col = col[COL_W-1:0];
		d.row = row[ROW_W-1:0];
		d.fin = 1'b0;
		char_cmds.push_back(d);
	endtask

	task automatic take_new_line();
		int i;
		cur_col = 0;
		if (cur_row < ROWS - 1) begin
			cur_row++;
		end else begin
			for (i = 0; i < ROWS - 1; i++)
				row_rec[i] = row_rec[i + 1];
			row_rec[ROWS - 1] = '0;
			emit_cmd(CMD_SCROLL, '0, 0, 0);
		end
	endtask

	// works out the display commands caused by one accepted character
	task automatic console_step(input logic [CHAR_W-1:0] code, input logic first,
			input logic last);
		bit stop;
		stop = 1'b0;
		char_cmds.delete();
		if (!halted_q) begin
			if (first)
				emit_cmd(CMD_ERASE, '0, cur_col, cur_row);
			if (code > CH_CTRL_LAST && code < CH_DEL) begin
				emit_cmd(CMD_DRAW, code[GLYPH_W-1:0], cur_col, cur_row);
				row_rec[cur_row] = cur_col[COL_W-1:0];
				cur_col++;
				if (cur_col >= COLS)
					take_new_line();
			end else if (code == CH_LF || code == CH_CR) begin
				take_new_line();
			end else if (code == CH_DEL) begin
				if (cur_col != 0) begin
					cur_col--;
					row_rec[cur_row] = cur_col[COL_W-1:0];
				end else if (cur_row != 0) begin
					row_rec[cur_row] = '0;
					cur_row--;
					cur_col = row_rec[cur_row];
				end
				emit_cmd(CMD_ERASE, '0, cur_col, cur_row);
			end else begin
				halted_q = 1'b1;
				emit_cmd(CMD_ERROR, '0, 0, 0);
				stop = 1'b1;
			end
			if (last && !stop)
				emit_cmd(CMD_DRAW, GLYPH_UNDERSCORE, cur_col, cur_row);
			if (char_cmds.size() != 0)
				char_cmds[char_cmds.size() - 1].fin = 1'b1;
			foreach (char_cmds[k])
				due_cmds.push_back(char_cmds[k]);
		end
	endtask

	task automatic queue_char(input logic [CHAR_W-1:0] code, input logic first,
			input logic last);
		char_req_t r;
		r.code = code;
		r.first = first;
		r.last = last;
		char_feed.push_back(r);
	endtask

	function automatic logic [CHAR_W-1:0] pick_char(input int nl_pct, input int del_pct);
		int r;
		r = $urandom_range(99);
		if (r < nl_pct)
			return $urandom_range(1) ? CH_LF : CH_CR;
		if (r < nl_pct + del_pct)
			return CH_DEL;
		return 8'($urandom_range(126, 32));
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			s_axis_tlast <= 1'b0;
			sent_cnt <= 0;
			load_phase <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				sent_cnt <= sent_cnt + 1;
			load_phase <= (sent_cnt * 3 < total_chars) ? 0 :
				(sent_cnt * 3 < total_chars * 2) ? 1 : 2;
			if (!s_axis_tvalid || s_axis_tready) begin
				if (char_feed.size() != 0 && $urandom_range(99) >= idle_pct(load_phase, 0)) begin
					next_req = char_feed.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_req.code;
					s_axis_tuser <= next_req.first;
					s_axis_tlast <= next_req.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: predicts on input requests, checks output requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			cur_col = 0;
			cur_row = 0;
			halted_q = 1'b0;
			for (int i = 0; i < ROWS; i++)
				row_rec[i] = '0;
			results_seen = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				console_step(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.cmd = cmd_t'(m_axis_tuser);
				got.glyph = m_axis_tdata[6:0];
				got.col = m_axis_tdata[14:7];
				got.row = m_axis_tdata[20:15];
				got.fin = m_axis_tlast;
				if (due_cmds.size() == 0) begin
					errors++;
					$display("%0t: unexpected command cmd=%0d glyph=%0d col=%0d row=%0d last=%0b",
						$time, got.cmd, got.glyph, got.col, got.row, got.fin);
				end else begin
					want = due_cmds.pop_front();
					if (got !== want) begin
						errors++;
						$display({"%0t: command mismatch: expected cmd=%0d glyph=%0d col=%0d ",
							"row=%0d last=%0b, got cmd=%0d glyph=%0d col=%0d row=%0d last=%0b"},
							$time, want.cmd, want.glyph, want.col, want.row, want.fin,
							got.cmd, got.glyph, got.col, got.row, got.fin);
					end
				end
				results_seen++;
			end
			// one long hold-off so the block backs up and stalls its input
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= idle_pct(load_phase, 1));
			end
		end
	end

	initial begin
		int kind;
		int len;
		int nl;
		int dl;
		bit noisy;
		bit first_str;
		logic [CHAR_W-1:0] bad;

		// directed: cursor at home, edges of printable range, both line ends, deletes
		queue_char(CH_DEL, 1'b1, 1'b1);
		queue_char(8'd65, 1'b0, 1'b0);
		queue_char(8'd32, 1'b1, 1'b0);
		queue_char(8'd126, 1'b0, 1'b1);
		queue_char(CH_DEL, 1'b1, 1'b1);
		queue_char(8'd85, 1'b0, 1'b0);
		queue_char(8'd42, 1'b0, 1'b0);
		queue_char(CH_LF, 1'b1, 1'b1);
		queue_char(CH_CR, 1'b0, 1'b0);
		queue_char(CH_DEL, 1'b0, 1'b1);
		queue_char(8'd120, 1'b1, 1'b0);
		queue_char(8'd121, 1'b0, 1'b0);
		queue_char(CH_LF, 1'b0, 1'b0);
		// delete at column 0 moves up to the recorded column
		queue_char(CH_DEL, 1'b0, 1'b1);
		queue_char(CH_DEL, 1'b1, 1'b0);
		queue_char(CH_DEL, 1'b0, 1'b0);
		queue_char(CH_DEL, 1'b0, 1'b0);
		queue_char(8'd127 - 8'd1, 1'b1, 1'b1);
		queue_char(CH_CR, 1'b1, 1'b0);

		// random strings; the first has no line ends or deletes and is within ten of a full line, so it can reach the wrap
		first_str = 1'b1;
		while (char_feed.size() < CHAR_TARGET) begin
			kind = first_str ? 0 : $urandom_range(24);
			first_str = 1'b0;
			case (kind)
				0: begin
					len = $urandom_range(COLS + 10, COLS - 10);
					nl = 0;
					dl = 0;
				end
				1, 2: begin
					len = $urandom_range(50, 20);
					nl = 100;
					dl = 0;
				end
				3: begin
					len = $urandom_range(12, 3);
					nl = 0;
					dl = 100;
				end
				default: begin
					len = $urandom_range(12, 1);
					nl = 15;
					dl = 15;
				end
			endcase
			noisy = ($urandom_range(9) == 0);
			for (int i = 0; i < len && char_feed.size() < CHAR_TARGET; i++)
				queue_char(pick_char(nl, dl),
					noisy ? 1'($urandom_range(1)) : (i == 0),
					noisy ? 1'($urandom_range(1)) : (i == len - 1));
		end

		// unsupported code halts; what follows must be ignored
		case ($urandom_range(2))
			0: bad = 8'($urandom_range(255, 128));
			1: bad = 8'($urandom_range(9, 0));
			default: bad = 8'($urandom_range(31, 14));
		endcase
		queue_char(bad, 1'($urandom_range(1)), 1'b1);
		queue_char(8'd65, 1'b1, 1'b1);
		queue_char(CH_LF, 1'b0, 1'b1);
		queue_char(8'hff, 1'b1, 1'b0);
		total_chars = char_feed.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (char_feed.size() != 0 || s_axis_tvalid || due_cmds.size() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

endmodule
